// ===== hw/rtl/sgre_pkg.sv =====
package sgre_pkg;

  localparam int ACC_W       = 32;
  localparam int FRAC_BITS   = 12;
  localparam int EXP_Q_BITS  = 16;
  localparam int EXP_IN_W    = 16;
  localparam int EINT_W      = 27;
  localparam int EFRAC_W     = 18;
  localparam int EXP_W       = 29;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic in_take;
    logic acc_upd;
    logic rd_issue;
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic row_done;
    logic out_free;
  } sts_t;

  function automatic logic [EINT_W-1:0] e_int(input logic [3:0] idx);
    logic [EINT_W-1:0] r;
    unique case (idx)
      4'd0:  r = 27'd22;
      4'd1:  r = 27'd60;
      4'd2:  r = 27'd162;
      4'd3:  r = 27'd442;
      4'd4:  r = 27'd1200;
      4'd5:  r = 27'd3263;
      4'd6:  r = 27'd8869;
      4'd7:  r = 27'd24109;
      4'd8:  r = 27'd65536;
      4'd9:  r = 27'd178145;
      4'd10: r = 27'd484249;
      4'd11: r = 27'd1316326;
      4'd12: r = 27'd3578144;
      4'd13: r = 27'd9726405;
      4'd14: r = 27'd26439109;
      4'd15: r = 27'd71868951;
    endcase
    return r;
  endfunction

  function automatic logic [EFRAC_W-1:0] e_frac(input logic [4:0] idx);
    logic [EFRAC_W-1:0] r;
    unique case (idx)
      5'd0:    r = 18'd65536;
      5'd1:    r = 18'd69763;
      5'd2:    r = 18'd74262;
      5'd3:    r = 18'd79052;
      5'd4:    r = 18'd84150;
      5'd5:    r = 18'd89577;
      5'd6:    r = 18'd95354;
      5'd7:    r = 18'd101504;
      5'd8:    r = 18'd108051;
      5'd9:    r = 18'd115019;
      5'd10:   r = 18'd122437;
      5'd11:   r = 18'd130334;
      5'd12:   r = 18'd138740;
      5'd13:   r = 18'd147688;
      5'd14:   r = 18'd157213;
      5'd15:   r = 18'd167352;
      5'd16:   r = 18'd178145;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/sgre_ctrl.sv =====
module sgre_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sgre_pkg::sts_t sts_i,
  output sgre_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ACC  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_S1   = 3'd3;
  localparam logic [2:0] ST_S2   = 3'd4;
  localparam logic [2:0] ST_S3   = 3'd5;
  localparam logic [2:0] ST_S4   = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.in_take = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc_upd = 1'b1;
        state_d       = sts_i.last ? ST_RD : ST_IDLE;
      end
      ST_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_S1;
      end
      ST_S1: begin
        cmd_o.s1 = 1'b1;
        state_d  = ST_S2;
      end
      ST_S2: begin
        cmd_o.s2 = 1'b1;
        state_d  = ST_S3;
      end
      ST_S3: begin
        cmd_o.s3 = 1'b1;
        state_d  = ST_S4;
      end
      ST_S4: begin
        cmd_o.s4 = 1'b1;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = sts_i.row_done ? ST_IDLE : ST_RD;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/sgre_datapath.sv =====
module sgre_datapath #(
  parameter int MAX_ROW_LEN = 64,
  parameter int DATA_WIDTH  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic signed [DATA_WIDTH-1:0] y_i,
  input  logic signed [DATA_WIDTH-1:0] dy_i,
  input  logic                         last_i,
  input  sgre_pkg::cmd_t               cmd_i,
  output sgre_pkg::sts_t               sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic        [DATA_WIDTH-1:0] dx_o,
  output logic                         last_o,
  output logic                         ovf_o
);

  localparam int DW    = DATA_WIDTH;
  localparam int AW    = $clog2(MAX_ROW_LEN);
  localparam int CW    = $clog2(MAX_ROW_LEN + 1);
  localparam int ACC_W = sgre_pkg::ACC_W;
  localparam int FB    = sgre_pkg::FRAC_BITS;
  localparam int PW    = 2 * DW;
  localparam int SW    = ((PW - FB > ACC_W) ? PW - FB : ACC_W) + 1;
  localparam int DFW   = ACC_W + 1;
  localparam int SPW   = ACC_W + DW;
  localparam int EW    = (DW > sgre_pkg::EXP_IN_W) ? DW : sgre_pkg::EXP_IN_W;
  localparam int XW    = sgre_pkg::EXP_W;
  localparam int QW    = XW + 1 + ACC_W;
  localparam int VW    = (SPW > QW) ? SPW : QW;
  localparam int EFW   = sgre_pkg::EFRAC_W;
  localparam int IPW   = EFW + 8;

  localparam logic signed [EW-1:0] YC_HI = EW'(32'sd32767);
  localparam logic signed [EW-1:0] YC_LO = EW'(-32'sd32768);
  localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};

  logic [PW-1:0] mem_q [MAX_ROW_LEN];
  logic [PW-1:0] rd_q;

  logic                    mode_q;
  logic [CW-1:0]           count_q;
  logic [AW-1:0]           idx_q;
  logic                    ovf_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    last_q;
  logic                    stored_q;
  logic                    item_mode_q;
  logic signed [PW-1:0]    prod_q;
  logic signed [DW-1:0]    dyin_q;

  logic signed [DW-1:0]    ry_q, rdy_q;
  logic signed [ACC_W-1:0] diff_q;
  logic [EFW-1:0]          base_q;
  logic [IPW-1:0]          interp_q;
  logic [3:0]              ii_q;
  logic signed [SPW-1:0]   p_q;
  logic [XW-1:0]           exp_q;
  logic signed [QW-1:0]    q_q;
  logic [DW-1:0]           res_q;
  logic                    res_last_q;
  logic                    res_ovf_q;

  logic                    out_valid_q;
  logic [DW-1:0]           out_dx_q;
  logic                    out_last_q;
  logic                    out_ovf_q;

  logic                    has_room;
  logic signed [PW-1:0]    in_prod;
  logic signed [SW-1:0]    addend, acc_sum;
  logic signed [DW-1:0]    rd_y, rd_dy;
  logic signed [DFW-1:0]   dsum;
  logic signed [ACC_W-1:0] diff_sat;
  logic signed [EW-1:0]    ye, yc;
  logic [15:0]             ebits;
  logic [EFW-1:0]          fr_lo, fr_hi, fr_dlt;
  logic [IPW-1:0]          iprod;
  logic [EFW-1:0]          g;
  logic [XW+15:0]          efull;
  logic signed [SPW-1:0]   p_d;
  logic signed [QW-1:0]    q_d;
  logic signed [QW-1:0]    lv;
  logic signed [VW-1:0]    v;
  logic [DW-1:0]           v_sat;
  logic                    row_end;

  assign has_room = (count_q < CW'(MAX_ROW_LEN));
  assign in_prod  = PW'(y_i) * PW'(dy_i);
  assign row_end  = cmd_i.out_load && res_last_q;

  always_comb begin
    if (item_mode_q) begin
      addend = SW'(dyin_q);
    end else begin
      addend = SW'(prod_q >>> FB);
    end
    acc_sum = SW'(acc_q) + addend;
    if (acc_sum[SW-1:ACC_W-1] != {(SW-ACC_W+1){acc_sum[SW-1]}}) begin
      acc_d = acc_sum[SW-1] ? sgre_pkg::ACC_MIN : sgre_pkg::ACC_MAX;
    end else begin
      acc_d = acc_sum[ACC_W-1:0];
    end
  end

  assign rd_y  = $signed(rd_q[DW-1:0]);
  assign rd_dy = $signed(rd_q[PW-1:DW]);

  always_comb begin
    dsum = DFW'(rd_dy) - DFW'(acc_q);
    if (dsum[DFW-1] != dsum[DFW-2]) begin
      diff_sat = dsum[DFW-1] ? sgre_pkg::ACC_MIN : sgre_pkg::ACC_MAX;
    end else begin
      diff_sat = dsum[ACC_W-1:0];
    end
  end

  // exp table lookup and interpolation
  always_comb begin
    ye = EW'(rd_y);
    if (ye > YC_HI) begin
      yc = YC_HI;
    end else if (ye < YC_LO) begin
      yc = YC_LO;
    end else begin
      yc = ye;
    end
    ebits  = {~yc[15], yc[14:0]};
    fr_lo  = sgre_pkg::e_frac({1'b0, ebits[11:8]});
    fr_hi  = sgre_pkg::e_frac({1'b0, ebits[11:8]} + 5'd1);
    fr_dlt = fr_hi - fr_lo;
    iprod  = IPW'(fr_dlt) * IPW'(ebits[7:0]);
  end

  assign g     = base_q + interp_q[IPW-1:8];
  assign efull = (XW+16)'(sgre_pkg::e_int(ii_q)) * (XW+16)'(g);
  assign p_d   = SPW'(diff_q) * SPW'(ry_q);
  assign q_d   = QW'($signed({1'b0, exp_q})) * QW'(acc_q);

  always_comb begin
    lv = QW'(rdy_q) - (q_q >>> sgre_pkg::EXP_Q_BITS);
    if (item_mode_q) begin
      v = VW'(lv);
    end else begin
      v = VW'(p_q >>> FB);
    end
    if (v[VW-1:DW-1] != {(VW-DW+1){v[VW-1]}}) begin
      v_sat = v[VW-1] ? D_MIN : D_MAX;
    end else begin
      v_sat = v[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take && has_room) begin
      mem_q[count_q[AW-1:0]] <= {dy_i, y_i};
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      acc_q       <= '0;
      last_q      <= 1'b0;
      stored_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (cmd_i.in_take) begin
        last_q   <= last_i;
        stored_q <= has_room;
        if (has_room) begin
          count_q <= count_q + CW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.acc_upd && stored_q) begin
        acc_q <= acc_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (row_end) begin
        acc_q   <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
        idx_q   <= '0;
      end else if (cmd_i.out_load) begin
        idx_q <= idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      prod_q      <= in_prod;
      dyin_q      <= dy_i;
      item_mode_q <= mode_q;
    end
    if (cmd_i.s1) begin
      ry_q     <= rd_y;
      rdy_q    <= rd_dy;
      diff_q   <= diff_sat;
      base_q   <= fr_lo;
      interp_q <= iprod;
      ii_q     <= ebits[15:12];
    end
    if (cmd_i.s2) begin
      p_q   <= p_d;
      exp_q <= efull[XW+15:16];
    end
    if (cmd_i.s3) begin
      q_q <= q_d;
    end
    if (cmd_i.s4) begin
      res_q      <= v_sat;
      res_last_q <= ((CW'(idx_q) + CW'(1)) == count_q);
      res_ovf_q  <= ovf_q;
    end
    if (cmd_i.out_load) begin
      out_dx_q   <= res_q;
      out_last_q <= res_last_q;
      out_ovf_q  <= res_ovf_q;
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.row_done = res_last_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign dx_o        = out_dx_q;
  assign last_o      = out_last_q;
  assign ovf_o       = out_ovf_q;

endmodule

// ===== hw/rtl/softmax_gradient_row_engine_top.sv =====
// loading: accept an element, then accumulate it into the row sum before taking the next
// once the element marked tlast is accumulated, emission of the row begins
// emission: buffer read, four arithmetic steps, load once output is free, then the next read
// a waiting output register lets the next row start loading after the last gradient is loaded
// rst_ni low clears the controller, row sum, element count, overflow flag and mode at once
// the row buffers are not cleared; no entry is read before it is written in the same row
module softmax_gradient_row_engine_top #(
  parameter int MAX_ROW_LEN = 64,
  parameter int DATA_WIDTH  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_wdata_i,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // y_value, dy_value
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  input  logic                                   s_axis_tlast_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // dx_value
  output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata_o,
  output logic                                   m_axis_tlast_o,
  // row_overflow
  output logic                                   m_axis_tuser_o
);

  localparam int OUT_TW = ((DATA_WIDTH + 7) / 8) * 8;

  sgre_pkg::cmd_t cmd;
  sgre_pkg::sts_t sts;
  logic [DATA_WIDTH-1:0] dx;

  sgre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sgre_datapath #(
    .MAX_ROW_LEN (MAX_ROW_LEN),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .y_i         ($signed(s_axis_tdata_i[DATA_WIDTH-1:0])),
    .dy_i        ($signed(s_axis_tdata_i[2*DATA_WIDTH-1:DATA_WIDTH])),
    .last_i      (s_axis_tlast_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .dx_o        (dx),
    .last_o      (m_axis_tlast_o),
    .ovf_o       (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = OUT_TW'(dx);

`ifndef NO_ASSERTIONS
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted during accumulate step");

  a_row_end_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && sts.row_done) |=> s_axis_tready_o)
    else $error("not ready for a new row after the last gradient");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid_o)
    else $error("loaded gradient not presented");
`endif

endmodule
